// ----- sv/tpd_pkg.sv -----
// shared types and constants of the planar tile row decoder
package tpd_pkg;

    // request kinds carried in the input tuser field
    typedef enum logic [1:0] {
        FUNC_WR_CHAR = 2'd0,
        FUNC_WR_DEF  = 2'd1,
        FUNC_DECODE  = 2'd2,
        FUNC_NONE    = 2'd3
    } t_func;

    localparam int CHAR_AW      = 15;
    localparam int DEF_AW       = 10;
    localparam int PLANE_AW     = 13;
    localparam int PLANE_COUNT  = 4;
    localparam int PIX_W        = 7;
    localparam int PIX_COUNT    = 8;
    localparam int SLOT_W       = 9;

    localparam logic [15:0] ENTRY_MASK = 16'hFDFF;
    localparam logic [8:0]  ANIM_CHARS = 9'd8;

    // decode request fields that travel past the definition lookup
    typedef struct packed {
        logic       bank;
        logic [2:0] row;
        logic [1:0] phase;
    } t_dec_side;

    // character fetch control derived from a definition entry
    typedef struct packed {
        logic [PLANE_AW-1:0] addr;
        logic [2:0]          pal;
        logic                hflip;
    } t_char_ctl;

endpackage

// ----- sv/tpd_ram.sv -----
// generic single write port ram with registered read
module tpd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read returns the old contents when the same address is written
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/tpd_char_addr.sv -----
// definition entry to character plane address, palette and flip
module tpd_char_addr #(
    parameter int ANIM_FRAMES = 4
) (
    input  logic [15:0]        i_entry,
    input  tpd_pkg::t_dec_side i_side,
    output tpd_pkg::t_char_ctl o_ctl
);

    import tpd_pkg::*;

    logic [15:0]       entry;
    logic [SLOT_W-1:0] chr;
    logic [SLOT_W-1:0] slot;
    logic [1:0]        phase_eff;
    logic [2:0]        sy;

    // bit 9 is not part of the entry
    assign entry = i_entry & ENTRY_MASK;
    assign chr   = entry[SLOT_W-1:0];

    // phases past the frame count show the static art
    assign phase_eff = (int'(i_side.phase) < ANIM_FRAMES) ? i_side.phase : 2'd0;

    // animated characters step by eight characters per phase
    assign slot = (chr < ANIM_CHARS) ? (chr + {4'd0, phase_eff, 3'd0}) : chr;

    // vertical flip mirrors the row
    assign sy = entry[15] ? ~i_side.row : i_side.row;

    assign o_ctl.addr  = {i_side.bank, slot, sy};
    assign o_ctl.pal   = entry[12:10];
    assign o_ctl.hflip = entry[14];

endmodule

// ----- sv/tpd_row_out.sv -----
// plane to pixel assembly and output register
module tpd_row_out (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_load,
    input  logic                                  i_valid,
    input  logic [7:0]                            i_plane [tpd_pkg::PLANE_COUNT],
    input  logic [2:0]                            i_pal,
    input  logic                                  i_hflip,
    output logic                                  o_valid,
    output logic [tpd_pkg::PIX_W*tpd_pkg::PIX_COUNT-1:0] o_pix
);

    import tpd_pkg::*;

    logic                            r_valid;
    logic [PIX_W*PIX_COUNT-1:0]      r_pix;
    logic [PIX_W*PIX_COUNT-1:0]      n_pix;

    // gather one bit per plane for each pixel, then add the palette
    always_comb begin
        logic [2:0] sh;
        logic [3:0] v;
        n_pix = '0;
        for (int x = 0; x < PIX_COUNT; x++) begin
            sh = i_hflip ? 3'(x) : 3'(PIX_COUNT - 1 - x);
            v  = {i_plane[3][sh], i_plane[2][sh], i_plane[1][sh], i_plane[0][sh]};
            n_pix[x*PIX_W +: PIX_W] = (v != 4'd0) ? {i_pal, v} : '0;
        end
    end

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_valid;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_pix <= n_pix;
        end
    end

    assign o_valid = r_valid;
    assign o_pix   = r_pix;

endmodule

// ----- sv/planar_tile_row_decoder.sv -----
// planar tile row decoder top level
//
// Requests enter on the s_axis channel; tuser carries the request kind:
// write character byte, write definition word or decode one row. Writes
// take effect in the cycle they are accepted and give no result. A decode
// request gives one row of eight 7-bit pixel indices on m_axis, leftmost
// pixel in the lowest bits, 0 meaning transparent.
// A decode passes through definition lookup, character plane fetch from four
// plane memories read in parallel, then pixel assembly into the output
// register. One request is accepted every cycle unless all stages are stalled.
// When the receiver stalls, results stay in the output register and the
// stages behind it keep filling; s_axis_tready drops only once every stage
// holds a decode result, so nothing is lost or repeated.
// Reset clears the stage valid bits only. Character and definition memory
// contents are undefined after reset and must be written before use; there
// is no clearing pass, requests are taken from the first cycle.
// A write accepted in the cycle after a decode is not seen by that decode;
// a decode accepted after a write sees it.
module planar_tile_row_decoder #(
    parameter int ANIM_FRAMES = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // char_address[14:0], char_data[22:15], def_address[32:23], def_word[48:33],
    // bank[49], tile[57:50], quadrant[59:58], row[62:60], phase[64:63], zero pad
    input  logic [71:0] s_axis_tdata,
    // func[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // pixel_0[6:0], pixel_1[13:7], ... pixel_7[55:49]
    output logic [55:0] m_axis_tdata
);

    import tpd_pkg::*;

    logic [CHAR_AW-1:0] char_address;
    logic [7:0]         char_data;
    logic [DEF_AW-1:0]  def_address;
    logic [15:0]        def_word;
    t_dec_side          side_in;
    logic [7:0]         tile;
    logic [1:0]         quadrant;
    t_func              func;

    logic               accept;
    logic               en1;
    logic               en2;
    logic               en3;
    logic               out_valid;

    logic               r_v1;
    t_dec_side          r_side1;
    logic [15:0]        def_rdata;
    t_char_ctl          char_ctl;

    logic               r_v2;
    logic [2:0]         r_pal2;
    logic               r_hflip2;
    logic [7:0]         plane [PLANE_COUNT];

    // unpack the request
    assign char_address  = s_axis_tdata[14:0];
    assign char_data     = s_axis_tdata[22:15];
    assign def_address   = s_axis_tdata[32:23];
    assign def_word      = s_axis_tdata[48:33];
    assign side_in.bank  = s_axis_tdata[49];
    assign tile          = s_axis_tdata[57:50];
    assign quadrant      = s_axis_tdata[59:58];
    assign side_in.row   = s_axis_tdata[62:60];
    assign side_in.phase = s_axis_tdata[64:63];
    assign func          = t_func'(s_axis_tuser);

    // a stage loads when it is empty or its contents move on
    assign en3           = !out_valid || m_axis_tready;
    assign en2           = !r_v2 || en3;
    assign en1           = !r_v1 || en2;
    assign s_axis_tready = en1;
    assign accept        = s_axis_tvalid && en1;

    // definition lookup
    tpd_ram #(
        .WIDTH(16),
        .DEPTH(1 << DEF_AW)
    ) u_def_ram (
        .i_clk  (i_clk),
        .i_we   (accept && (func == FUNC_WR_DEF)),
        .i_waddr(def_address),
        .i_wdata(def_word),
        .i_re   (en1),
        .i_raddr({tile, quadrant}),
        .o_rdata(def_rdata)
    );

    // stage one valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en1) begin
            r_v1 <= accept && (func == FUNC_DECODE);
        end
    end

    // stage one payload
    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_side1 <= side_in;
        end
    end

    tpd_char_addr #(
        .ANIM_FRAMES(ANIM_FRAMES)
    ) u_char_addr (
        .i_entry(def_rdata),
        .i_side (r_side1),
        .o_ctl  (char_ctl)
    );

    // character planes split by address bits 4 and 0
    for (genvar g = 0; g < PLANE_COUNT; g++) begin : g_plane
        tpd_ram #(
            .WIDTH(8),
            .DEPTH(1 << PLANE_AW)
        ) u_char_ram (
            .i_clk  (i_clk),
            .i_we   (accept && (func == FUNC_WR_CHAR) &&
                     (char_address[4] == 1'(g / 2)) && (char_address[0] == 1'(g % 2))),
            .i_waddr({char_address[14:5], char_address[3:1]}),
            .i_wdata(char_data),
            .i_re   (en2),
            .i_raddr(char_ctl.addr),
            .o_rdata(plane[g])
        );
    end

    // stage two valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (en2) begin
            r_v2 <= r_v1;
        end
    end

    // stage two payload
    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_pal2   <= char_ctl.pal;
            r_hflip2 <= char_ctl.hflip;
        end
    end

    tpd_row_out u_row_out (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_load (en3),
        .i_valid(r_v2),
        .i_plane(plane),
        .i_pal  (r_pal2),
        .i_hflip(r_hflip2),
        .o_valid(out_valid),
        .o_pix  (m_axis_tdata)
    );

    assign m_axis_tvalid = out_valid;

`ifndef NO_ASSERTIONS
    // a decode request always lands in stage one
    a_decode_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (func == FUNC_DECODE)) |=> r_v1)
        else $error("decode request not captured in stage one");

    // write requests never start a result
    a_write_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (func != FUNC_DECODE)) |=> !r_v1)
        else $error("non-decode request produced a stage one entry");

    // a blocked stage two keeps its entry
    a_stage2_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && out_valid && !m_axis_tready) |=> (r_v2 && $stable(r_pal2)))
        else $error("stage two lost its entry during a stall");

    // no request is taken while every stage is full and stalled
    a_full_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && r_v2 && out_valid && !m_axis_tready) |-> !s_axis_tready)
        else $error("request accepted into a full pipeline");
`endif

endmodule

// ----- verif/tpd_row_checker.sv -----
`timescale 1ns / 1ps
// checker of the planar tile row decoder: tracks both stores and compares decoded rows
module tpd_row_checker #(
    parameter int ANIM_FRAMES = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    // char_address[14:0], char_data[22:15], def_address[32:23], def_word[48:33],
    // bank[49], tile[57:50], quadrant[59:58], row[62:60], phase[64:63], zero pad
    input  logic [71:0] s_axis_tdata,
    // func[1:0]
    input  logic [1:0]  s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // pixel_0[6:0], pixel_1[13:7], ... pixel_7[55:49]
    input  logic [55:0] m_axis_tdata,
    output int          o_fail_count,
    output int          o_pending
);

    import tpd_pkg::*;

    localparam int BANK_BYTES = 16384;

    // request word as it travels on tdata, highest field first
    typedef struct packed {
        logic [6:0]  pad;
        logic [1:0]  phase;
        logic [2:0]  row;
        logic [1:0]  quad;
        logic [7:0]  tile;
        logic        bank;
        logic [15:0] def_word;
        logic [9:0]  def_address;
        logic [7:0]  char_data;
        logic [14:0] char_address;
    } t_request_word;

    typedef logic [PIX_COUNT-1:0][PIX_W-1:0] t_pix_row;

    // private copies of the character banks and the metatile table
    logic [7:0]  char_image [2**CHAR_AW];
    logic [15:0] def_table  [2**DEF_AW];
    t_pix_row    expected_rows [$];

    // one row of color indices for a decode request
    function automatic t_pix_row decode_row(logic bank, logic [7:0] tile, logic [1:0] quad,
                                            logic [2:0] row, logic [1:0] phase);
        logic [15:0] entry;
        logic [8:0]  chr;
        logic [2:0]  pal;
        logic [2:0]  src_row;
        int unsigned base;
        int unsigned offset;
        logic [7:0]  plane [PLANE_COUNT];
        logic [3:0]  value;
        int          bit_sel;
        t_pix_row    pix;
        entry   = def_table[{tile, quad}] & ENTRY_MASK;
        chr     = entry[8:0];
        pal     = entry[12:10];
        src_row = entry[15] ? 3'd7 - row : row;
        base    = chr * 32;
        // animated characters move by one 256-byte slice per phase
        if (chr < ANIM_CHARS && phase < ANIM_FRAMES)
            base += phase * 256;
        // planes 0/1 sit in the first half of the character, 2/3 sixteen bytes on
        for (int p = 0; p < PLANE_COUNT; p++) begin
            offset   = (base + src_row * 2 + (p % 2) + (p / 2) * 16) % BANK_BYTES;
            plane[p] = char_image[{bank, offset[13:0]}];
        end
        for (int x = 0; x < PIX_COUNT; x++) begin
            bit_sel = entry[14] ? x : 7 - x;
            value   = {plane[3][bit_sel], plane[2][bit_sel], plane[1][bit_sel],
                       plane[0][bit_sel]};
            pix[x]  = (value != 4'd0) ? {pal, value} : '0;
        end
        return pix;
    endfunction

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // compare finished rows, then apply the request taken at this edge
    always @(posedge i_clk) begin
        t_pix_row      got;
        t_pix_row      want;
        t_request_word req;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata;
                if (expected_rows.size() == 0) begin
                    $error("pixel row %h with no decode request waiting", got);
                    o_fail_count++;
                end else begin
                    want = expected_rows.pop_front();
                    for (int k = 0; k < PIX_COUNT; k++) begin
                        if (got[k] !== want[k]) begin
                            $error("pixel_%0d expected %0d got %0d", k, want[k], got[k]);
                            o_fail_count++;
                        end
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                req = s_axis_tdata;
                case (t_func'(s_axis_tuser))
                    FUNC_WR_CHAR: begin
                        char_image[req.char_address] = req.char_data;
                    end
                    FUNC_WR_DEF: begin
                        def_table[req.def_address] = req.def_word;
                    end
                    FUNC_DECODE: begin
                        expected_rows.push_back(decode_row(req.bank, req.tile, req.quad,
                                                           req.row, req.phase));
                    end
                    default: begin
                    end
                endcase
            end
            o_pending = expected_rows.size();
        end
    end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// top of the planar tile row decoder testbench: request stream, handshakes and verdict
module testbench;
    import tpd_pkg::*;

    localparam int ANIM_FRAMES  = 4;
    localparam int BANK_BYTES   = 16384;
    localparam int ITEM_TARGET  = 1550;
    localparam int QUIET_LIMIT  = 3000;
    localparam int DRAIN_CYCLES = 8;

    typedef struct packed {
        t_func       func;
        logic [1:0]  phase;
        logic [2:0]  row;
        logic [1:0]  quad;
        logic [7:0]  tile;
        logic        bank;
        logic [15:0] def_word;
        logic [9:0]  def_address;
        logic [7:0]  char_data;
        logic [14:0] char_address;
    } t_request;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata  = '0;
    logic [1:0]  s_axis_tuser  = FUNC_NONE;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;

    int fail_count;
    int pending_rows;
    int stall_pct   = 77;
    int quiet_cycles = 0;

    // what the request stream has written so far, so decodes only read filled entries
    t_request    request_list [$];
    bit          char_seen  [2**CHAR_AW];
    bit          def_seen   [2**DEF_AW];
    logic [15:0] def_shadow [2**DEF_AW];
    int          item_count = 0;

    planar_tile_row_decoder #(
        .ANIM_FRAMES(ANIM_FRAMES)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    tpd_row_checker #(
        .ANIM_FRAMES(ANIM_FRAMES)
    ) i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending_rows)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // every field random, unused ones included
    function automatic t_request random_request(t_func func);
        t_request r;
        r.func         = func;
        r.phase        = 2'($urandom_range(0, 3));
        r.row          = 3'($urandom_range(0, 7));
        r.quad         = 2'($urandom_range(0, 3));
        r.tile         = 8'($urandom_range(0, 255));
        r.bank         = 1'($urandom_range(0, 1));
        r.def_word     = 16'($urandom_range(0, 65535));
        r.def_address  = 10'($urandom_range(0, 1023));
        r.char_data    = 8'($urandom_range(0, 255));
        r.char_address = 15'($urandom_range(0, 32767));
        return r;
    endfunction

    task automatic queue_request(t_request r);
        request_list.push_back(r);
        if (r.func != FUNC_NONE)
            item_count++;
        if (r.func == FUNC_WR_CHAR)
            char_seen[r.char_address] = 1'b1;
        if (r.func == FUNC_WR_DEF) begin
            def_seen[r.def_address]   = 1'b1;
            def_shadow[r.def_address] = r.def_word;
        end
    endtask

    // decode preceded by whatever writes its entry and four plane bytes still need
    task automatic queue_decode(logic bank, logic [7:0] tile, logic [1:0] quad,
                                logic [2:0] row, logic [1:0] phase, bit new_def,
                                logic [15:0] word, int fill);
        t_request    r;
        logic [9:0]  slot;
        logic [15:0] entry;
        int unsigned base;
        int unsigned src_row;
        int unsigned addr;
        slot = {tile, quad};
        if (new_def || !def_seen[slot]) begin
            r             = random_request(FUNC_WR_DEF);
            r.def_address = slot;
            r.def_word    = word;
            queue_request(r);
        end
        entry   = def_shadow[slot];
        base    = entry[8:0] * 32;
        if (entry[8:0] < ANIM_CHARS && phase < ANIM_FRAMES)
            base += phase * 256;
        src_row = entry[15] ? 7 - row : row;
        for (int p = 0; p < PLANE_COUNT; p++) begin
            addr = bank * BANK_BYTES + (base + src_row * 2 + (p % 2) + (p / 2) * 16) % BANK_BYTES;
            if (!char_seen[addr]) begin
                r              = random_request(FUNC_WR_CHAR);
                r.char_address = 15'(addr);
                r.char_data    = (fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill);
                queue_request(r);
            end
        end
        r      = random_request(FUNC_DECODE);
        r.bank = bank;
        r.tile = tile;
        r.quad = quad;
        r.row  = row;
        r.phase = phase;
        queue_request(r);
    endtask

    // receiver back-pressure, rate set by the sender's progress
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // stop a hung run
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        t_request    r;
        logic [7:0]  tile;
        logic [15:0] word;
        int          pick;
        int          total;
        int          next_idx;
        int          accepted;
        int          stage;
        int          send_idle_pct;

        // directed: full-scale pixels with both flips and the top table slot
        queue_decode(1'b1, 8'd255, 2'd3, 3'd0, 2'd0, 1'b1, 16'hFFFF, 255);
        // all-transparent row on an animated character at the last phase
        queue_decode(1'b0, 8'd0, 2'd0, 3'd7, 2'd3, 1'b1, 16'h0000, 0);
        // horizontal flip, animated character 7 at phase 2
        queue_decode(1'b0, 8'd1, 2'd1, 3'd3, 2'd2, 1'b1, 16'h4C07, -1);
        // vertical flip, ignored bit 9 set, first static character
        queue_decode(1'b1, 8'd2, 2'd2, 3'd5, 2'd1, 1'b1, 16'h8208, -1);
        // unused request kind
        queue_request(random_request(FUNC_NONE));

        // random: mostly complete decode sequences over a small character pool
        while (item_count < ITEM_TARGET) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                queue_request(random_request(FUNC_WR_CHAR));
            end else if (pick < 12) begin
                queue_request(random_request(FUNC_WR_DEF));
            end else if (pick < 16) begin
                queue_request(random_request(FUNC_NONE));
            end else begin
                tile = ($urandom_range(0, 99) < 60) ? 8'($urandom_range(0, 15))
                                                     : 8'($urandom_range(0, 255));
                word = 16'($urandom_range(0, 65535));
                pick = $urandom_range(0, 99);
                if (pick < 40)
                    word[8:0] = 9'($urandom_range(0, 7));
                else if (pick < 70)
                    word[8:0] = 9'($urandom_range(8, 23));
                queue_decode(1'($urandom_range(0, 1)), tile, 2'($urandom_range(0, 3)),
                             3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)),
                             $urandom_range(0, 3) == 0, word, -1);
            end
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // request stream in three idling stages
        total    = request_list.size();
        next_idx = 0;
        accepted = 0;
        while (accepted < total) begin
            @(posedge i_clk);
            if (s_axis_tvalid && s_axis_tready)
                accepted++;
            stage         = next_idx * 3 / total;
            send_idle_pct = (stage == 0) ? 17 : (stage == 1) ? 77 : 0;
            stall_pct     <= (stage == 0) ? 77 : (stage == 1) ? 17 : 0;
            if (!s_axis_tvalid || s_axis_tready) begin
                if (next_idx < total && $urandom_range(0, 99) >= send_idle_pct) begin
                    r = request_list[next_idx];
                    next_idx++;
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {7'd0, r.phase, r.row, r.quad, r.tile, r.bank,
                                      r.def_word, r.def_address, r.char_data, r.char_address};
                    s_axis_tuser  <= r.func;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end

        // drain the pipeline, then keep watching for stray rows
        while (pending_rows != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_rows == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ----- files.f -----
sv/tpd_pkg.sv
sv/tpd_ram.sv
sv/tpd_char_addr.sv
sv/tpd_row_out.sv
sv/planar_tile_row_decoder.sv
verif/tpd_row_checker.sv
verif/testbench.sv
